// File: rtl/svgp_pkg.sv
// shared types and constants for the spatial voice gain and pan block
// used by spatial_voice_gain_pan; depends on nothing
package svgp_pkg;

  localparam int ONE_Q14 = 16384;
  localparam int ONE_Q15 = 32768;
  localparam int ONE_Q28 = 268435456;
  localparam int RND_Q15 = 16384;

  localparam logic [59:0] TINY_Q28 = 60'd268;
  localparam logic [59:0] TINY_Q56 = 60'd72057594037;

  // register indexes
  localparam logic [2:0] REG_LX    = 3'd0;
  localparam logic [2:0] REG_LY    = 3'd1;
  localparam logic [2:0] REG_LZ    = 3'd2;
  localparam logic [2:0] REG_FWD   = 3'd3;
  localparam logic [2:0] REG_UP    = 3'd4;
  localparam logic [2:0] REG_OCHAN = 3'd5;

  // basis vector being normalized
  localparam logic [1:0] JOB_FWD = 2'd0;
  localparam logic [1:0] JOB_UP  = 2'd1;
  localparam logic [1:0] JOB_RT  = 2'd2;

  // pipeline stage map
  localparam int NS     = 66;
  localparam int K_DIFF = 0;
  localparam int K_SQ   = 1;
  localparam int K_SUM  = 2;
  localparam int K_RT0  = 3;
  localparam int K_RT1  = 28;
  localparam int K_ATT  = 29;
  localparam int K_DV0  = 30;
  localparam int K_DV1  = 44;
  localparam int K_BASE = 45;
  localparam int K_DOT  = 46;
  localparam int K_PAN  = 47;
  localparam int K_GR0  = 48;
  localparam int K_GR1  = 63;
  localparam int K_GMUL = 64;
  localparam int K_OUT  = 65;

  typedef enum logic [2:0] {
    CS_IDLE,
    CS_LOAD,
    CS_SQ,
    CS_CHK,
    CS_ROOT,
    CS_DINIT,
    CS_DIV,
    CS_STORE
  } cfg_state_t;

  typedef struct packed {
    logic [7:0]         tag;
    logic [15:0]        vol;
    logic [23:0]        nd;
    logic [23:0]        fd;
    logic signed [24:0] dx;
    logic signed [24:0] dy;
    logic signed [24:0] dz;
    logic [2:0][49:0]   sq;
    logic [51:0]        sv;
    logic [51:0]        sr;
    logic               nz;
    logic [25:0]        dlen;
    logic               full;
    logic               zero;
    logic [23:0]        aden;
    logic [3:0][39:0]   rem;
    logic [3:0][14:0]   q;
    logic [2:0]         sgn;
    logic [2:0][15:0]   dn;
    logic [31:0]        prod;
    logic [15:0]        base;
    logic [2:0][31:0]   pp;
    logic [1:0][31:0]   gv;
    logic [1:0][31:0]   gr;
    logic [1:0][31:0]   pl;
    logic [15:0]        left;
    logic [15:0]        right;
    logic               panned;
  } pipe_t;

endpackage

// File: rtl/spatial_voice_gain_pan.sv
// top level of the spatial voice gain and pan block: apb registers, basis
// sequencer and the per-voice pipeline; depends on svgp_pkg

// Each voice update passes a 66-stage pipeline, at up to one update per
// clock; a stall on the output fills bubbles before it holds the input.
// Distance, attenuation, direction and the two pan gains use unrolled
// square root and restoring divide stages, one step per stage. A write to
// the forward or up vector starts a sequencer with one shared multiplier,
// square root and divider that renormalizes forward, up and right; the
// input holds tready low until it is done.
module spatial_voice_gain_pan (
  input  logic         clk,
  input  logic         rst,
  // tag, source_x, source_y, source_z, voice_volume, near_distance, far_distance
  input  logic [143:0] s_axis_tdata,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // result_tag, base_gain, left_gain, right_gain, panned
  output logic [63:0]  m_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [5:0]   paddr,
  input  logic [63:0]  pwdata,
  output logic [63:0]  prdata,
  output logic         pready
);
  import svgp_pkg::*;

  logic [23:0] lx, ly, lz;
  logic [47:0] fwd, up;
  logic [3:0]  ochan;
  logic        cfg_wr, vec_wr, busy;
  logic [2:0]  ridx;

  assign pready = 1'b1;
  assign ridx   = paddr[5:3];
  assign cfg_wr = psel & penable & pwrite;
  assign vec_wr = cfg_wr && (ridx == REG_FWD || ridx == REG_UP);

  always_ff @(posedge clk) begin
    if (rst) begin
      lx    <= '0;
      ly    <= '0;
      lz    <= '0;
      fwd   <= 48'(ONE_Q14);
      up    <= 48'(ONE_Q14) << 16;
      ochan <= 4'd2;
    end else if (cfg_wr) begin
      unique case (ridx)
        REG_LX:    lx    <= pwdata[23:0];
        REG_LY:    ly    <= pwdata[23:0];
        REG_LZ:    lz    <= pwdata[23:0];
        REG_FWD:   fwd   <= pwdata[47:0];
        REG_UP:    up    <= pwdata[47:0];
        REG_OCHAN: ochan <= pwdata[3:0];
        default:   ;
      endcase
    end
  end

  always_comb begin
    unique case (ridx)
      REG_LX:    prdata = {40'd0, lx};
      REG_LY:    prdata = {40'd0, ly};
      REG_LZ:    prdata = {40'd0, lz};
      REG_FWD:   prdata = {16'd0, fwd};
      REG_UP:    prdata = {16'd0, up};
      REG_OCHAN: prdata = {60'd0, ochan};
      default:   prdata = '0;
    endcase
  end

  // basis sequencer
  cfg_state_t         state, state_next;
  logic [1:0]         job, comp;
  logic [3:0]         cnt;
  logic signed [29:0] vec [3];
  logic [59:0]        prod, acc, rt, bsq;
  logic [44:0]        rem, dsh;
  logic [14:0]        quo;
  logic signed [15:0] res [3];
  logic signed [15:0] nfw [3];
  logic signed [15:0] nup [3];
  logic signed [15:0] nrt [3];
  logic signed [31:0] cr [3];
  logic signed [29:0] vsel, csel;
  logic [60:0]        rtry;
  logic               dge;
  logic [14:0]        qn;
  logic [28:0]        cmag;
  logic [59:0]        tiny;

  assign cr[0] = nup[1] * nfw[2] - nup[2] * nfw[1];
  assign cr[1] = nup[2] * nfw[0] - nup[0] * nfw[2];
  assign cr[2] = nup[0] * nfw[1] - nup[1] * nfw[0];

  always_comb begin
    unique case (cnt[1:0])
      2'd0:    vsel = vec[0];
      2'd1:    vsel = vec[1];
      2'd2:    vsel = vec[2];
      default: vsel = '0;
    endcase
    unique case (comp)
      2'd0:    csel = vec[0];
      2'd1:    csel = vec[1];
      default: csel = vec[2];
    endcase
  end

  assign cmag = csel[29] ? 29'(-csel) : csel[28:0];
  assign rtry = {1'b0, rt} + {1'b0, bsq};
  assign dge  = rem >= dsh;
  assign qn   = {quo[13:0], dge};
  assign tiny = (job == JOB_RT) ? TINY_Q56 : TINY_Q28;

  always_comb begin
    state_next = state;
    unique case (state)
      CS_IDLE:  state_next = CS_IDLE;
      CS_LOAD:  state_next = CS_SQ;
      CS_SQ:    if (cnt == 4'd3) state_next = CS_CHK;
      CS_CHK:   state_next = (acc <= tiny) ? CS_STORE : CS_ROOT;
      CS_ROOT:  if (bsq == 60'd1) state_next = CS_DINIT;
      CS_DINIT: state_next = CS_DIV;
      CS_DIV:   if (cnt == 4'd0) state_next = (comp == 2'd2) ? CS_STORE : CS_DINIT;
      CS_STORE: state_next = (job == JOB_RT) ? CS_IDLE : CS_LOAD;
      default:  state_next = CS_IDLE;
    endcase
    if (vec_wr) state_next = CS_LOAD;
  end

  always_comb begin
    busy = (state != CS_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= CS_IDLE;
      job   <= JOB_FWD;
      nfw[0] <= '0; nfw[1] <= '0; nfw[2] <= 16'(ONE_Q14);
      nup[0] <= '0; nup[1] <= 16'(ONE_Q14); nup[2] <= '0;
      nrt[0] <= 16'(ONE_Q14); nrt[1] <= '0; nrt[2] <= '0;
    end else begin
      state <= state_next;
      unique case (state)
        CS_LOAD: begin
          unique case (job)
            JOB_FWD: begin
              vec[0] <= 30'($signed(fwd[47:32]));
              vec[1] <= 30'($signed(fwd[31:16]));
              vec[2] <= 30'($signed(fwd[15:0]));
            end
            JOB_UP: begin
              vec[0] <= 30'($signed(up[47:32]));
              vec[1] <= 30'($signed(up[31:16]));
              vec[2] <= 30'($signed(up[15:0]));
            end
            default: begin
              vec[0] <= cr[0][29:0];
              vec[1] <= cr[1][29:0];
              vec[2] <= cr[2][29:0];
            end
          endcase
          prod <= '0;
          acc  <= '0;
          cnt  <= '0;
        end
        CS_SQ: begin
          prod <= vsel * vsel;
          acc  <= acc + prod;
          cnt  <= cnt + 4'd1;
        end
        CS_CHK: begin
          rt   <= '0;
          bsq  <= 60'd1 << 58;
          comp <= '0;
          unique case (job)
            JOB_FWD: begin
              res[0] <= '0; res[1] <= '0; res[2] <= 16'(ONE_Q14);
            end
            JOB_UP: begin
              res[0] <= '0; res[1] <= 16'(ONE_Q14); res[2] <= '0;
            end
            default: begin
              res[0] <= 16'(ONE_Q14); res[1] <= '0; res[2] <= '0;
            end
          endcase
        end
        CS_ROOT: begin
          if ({1'b0, acc} >= rtry) begin
            acc <= acc - rtry[59:0];
            rt  <= (rt >> 1) + bsq;
          end else begin
            rt <= rt >> 1;
          end
          bsq <= bsq >> 2;
        end
        CS_DINIT: begin
          rem <= {2'b0, cmag, 14'd0};
          dsh <= 45'(rt[30:0]) << 14;
          quo <= '0;
          cnt <= 4'd14;
        end
        CS_DIV: begin
          if (dge) rem <= rem - dsh;
          dsh <= dsh >> 1;
          quo <= qn;
          cnt <= cnt - 4'd1;
          if (cnt == 4'd0) begin
            unique case (comp)
              2'd0:    res[0] <= csel[29] ? -{1'b0, qn} : {1'b0, qn};
              2'd1:    res[1] <= csel[29] ? -{1'b0, qn} : {1'b0, qn};
              default: res[2] <= csel[29] ? -{1'b0, qn} : {1'b0, qn};
            endcase
            comp <= comp + 2'd1;
          end
        end
        CS_STORE: begin
          unique case (job)
            JOB_FWD: begin
              nfw[0] <= res[0]; nfw[1] <= res[1]; nfw[2] <= res[2];
            end
            JOB_UP: begin
              nup[0] <= res[0]; nup[1] <= res[1]; nup[2] <= res[2];
            end
            default: begin
              nrt[0] <= res[0]; nrt[1] <= res[1]; nrt[2] <= res[2];
            end
          endcase
          job <= job + 2'd1;
        end
        default: ;
      endcase
      if (vec_wr) job <= JOB_FWD;
    end
  end

  // voice pipeline
  pipe_t          st  [NS];
  pipe_t          nxt [NS];
  logic [NS-1:0]  vld, rdy, upv;
  logic           in_fire;

  assign s_axis_tready = rdy[0] && !busy;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  for (genvar k = 0; k < NS; k++) begin : g_stage
    if (k == NS - 1) begin : g_rlast
      assign rdy[k] = !vld[k] || m_axis_tready;
    end else begin : g_rmid
      assign rdy[k] = !vld[k] || rdy[k+1];
    end

    if (k == K_DIFF) begin : g_diff
      assign upv[k] = in_fire;
      always_comb begin
        logic [23:0] near_v, far_v, n_v;
        logic [15:0] vol_v;
        near_v = {1'b0, s_axis_tdata[118:96]};
        far_v  = {1'b0, s_axis_tdata[141:119]};
        vol_v  = s_axis_tdata[95:80];
        n_v    = (near_v == '0) ? 24'd1 : near_v;
        nxt[k]     = '0;
        nxt[k].tag = s_axis_tdata[7:0];
        nxt[k].vol = (vol_v > 16'(ONE_Q15)) ? 16'(ONE_Q15) : vol_v;
        nxt[k].nd  = n_v;
        nxt[k].fd  = (far_v < n_v + 24'd1) ? n_v + 24'd1 : far_v;
        nxt[k].dx  = {s_axis_tdata[31], s_axis_tdata[31:8]} - {lx[23], lx};
        nxt[k].dy  = {s_axis_tdata[55], s_axis_tdata[55:32]} - {ly[23], ly};
        nxt[k].dz  = {s_axis_tdata[79], s_axis_tdata[79:56]} - {lz[23], lz};
      end
    end else begin : g_next
      assign upv[k] = vld[k-1];
      if (k == K_SQ) begin : g_sq
        always_comb begin
          nxt[k]       = st[k-1];
          nxt[k].sq[0] = st[k-1].dx * st[k-1].dx;
          nxt[k].sq[1] = st[k-1].dy * st[k-1].dy;
          nxt[k].sq[2] = st[k-1].dz * st[k-1].dz;
        end
      end else if (k == K_SUM) begin : g_sum
        always_comb begin
          nxt[k]    = st[k-1];
          nxt[k].sv = 52'(st[k-1].sq[0]) + 52'(st[k-1].sq[1]) + 52'(st[k-1].sq[2]);
          nxt[k].nz = (nxt[k].sv != '0);
          nxt[k].sr = '0;
        end
      end else if (k >= K_RT0 && k <= K_RT1) begin : g_root
        localparam logic [51:0] BIT = 52'd1 << (2 * (K_RT1 - k));
        always_comb begin
          logic [52:0] t;
          t      = {1'b0, st[k-1].sr} + {1'b0, BIT};
          nxt[k] = st[k-1];
          if ({1'b0, st[k-1].sv} >= t) begin
            nxt[k].sv = st[k-1].sv - t[51:0];
            nxt[k].sr = (st[k-1].sr >> 1) + BIT;
          end else begin
            nxt[k].sr = st[k-1].sr >> 1;
          end
        end
      end else if (k == K_ATT) begin : g_att
        always_comb begin
          logic [25:0] d_v, diff;
          logic [24:0] m0, m1, m2;
          d_v  = st[k-1].sr[25:0];
          diff = {2'b0, st[k-1].fd} - d_v;
          m0   = st[k-1].dx[24] ? -st[k-1].dx : st[k-1].dx;
          m1   = st[k-1].dy[24] ? -st[k-1].dy : st[k-1].dy;
          m2   = st[k-1].dz[24] ? -st[k-1].dz : st[k-1].dz;
          nxt[k]        = st[k-1];
          nxt[k].dlen   = d_v;
          nxt[k].full   = d_v <= {2'b0, st[k-1].nd};
          nxt[k].zero   = d_v >= {2'b0, st[k-1].fd};
          nxt[k].aden   = st[k-1].fd - st[k-1].nd;
          nxt[k].rem[0] = {1'b0, diff[23:0], 15'd0};
          nxt[k].rem[1] = {2'b0, m0[23:0], 14'd0};
          nxt[k].rem[2] = {2'b0, m1[23:0], 14'd0};
          nxt[k].rem[3] = {2'b0, m2[23:0], 14'd0};
          nxt[k].sgn    = {st[k-1].dz[24], st[k-1].dy[24], st[k-1].dx[24]};
          nxt[k].q      = '0;
        end
      end else if (k >= K_DV0 && k <= K_DV1) begin : g_div
        localparam int KB = K_DV1 - k;
        always_comb begin
          logic [39:0] dd;
          nxt[k] = st[k-1];
          for (int l = 0; l < 4; l++) begin
            dd = (l == 0) ? (40'(st[k-1].aden) << KB) : (40'(st[k-1].dlen) << KB);
            if (st[k-1].rem[l] >= dd) begin
              nxt[k].rem[l]   = st[k-1].rem[l] - dd;
              nxt[k].q[l][KB] = 1'b1;
            end
          end
        end
      end else if (k == K_BASE) begin : g_base
        always_comb begin
          logic [15:0] att;
          if (st[k-1].full)      att = 16'(ONE_Q15);
          else if (st[k-1].zero) att = '0;
          else                   att = {1'b0, st[k-1].q[0]};
          nxt[k]      = st[k-1];
          nxt[k].prod = 32'(st[k-1].vol) * 32'(att);
          for (int i = 0; i < 3; i++) begin
            nxt[k].dn[i] = st[k-1].sgn[i] ? -{1'b0, st[k-1].q[i+1]} : {1'b0, st[k-1].q[i+1]};
          end
        end
      end else if (k == K_DOT) begin : g_dot
        always_comb begin
          logic [31:0] rb;
          rb        = st[k-1].prod + 32'(RND_Q15);
          nxt[k]       = st[k-1];
          nxt[k].base  = rb[30:15];
          nxt[k].pp[0] = $signed(st[k-1].dn[0]) * nrt[0];
          nxt[k].pp[1] = $signed(st[k-1].dn[1]) * nrt[1];
          nxt[k].pp[2] = $signed(st[k-1].dn[2]) * nrt[2];
        end
      end else if (k == K_PAN) begin : g_pan
        always_comb begin
          logic signed [33:0] s, pan, dl, dr;
          s = 34'($signed(st[k-1].pp[0])) + 34'($signed(st[k-1].pp[1]))
            + 34'($signed(st[k-1].pp[2]));
          if (s > 34'sd268435456)       pan = 34'sd268435456;
          else if (s < -34'sd268435456) pan = -34'sd268435456;
          else                          pan = s;
          dl = 34'(ONE_Q28) - pan;
          dr = 34'(ONE_Q28) + pan;
          nxt[k]       = st[k-1];
          nxt[k].gv[0] = {dl[30:0], 1'b0};
          nxt[k].gv[1] = {dr[30:0], 1'b0};
          nxt[k].gr    = '0;
        end
      end else if (k >= K_GR0 && k <= K_GR1) begin : g_groot
        localparam logic [31:0] BIT = 32'd1 << (2 * (K_GR1 - k));
        always_comb begin
          logic [32:0] t;
          nxt[k] = st[k-1];
          for (int l = 0; l < 2; l++) begin
            t = {1'b0, st[k-1].gr[l]} + {1'b0, BIT};
            if ({1'b0, st[k-1].gv[l]} >= t) begin
              nxt[k].gv[l] = st[k-1].gv[l] - t[31:0];
              nxt[k].gr[l] = (st[k-1].gr[l] >> 1) + BIT;
            end else begin
              nxt[k].gr[l] = st[k-1].gr[l] >> 1;
            end
          end
        end
      end else if (k == K_GMUL) begin : g_gmul
        always_comb begin
          nxt[k]       = st[k-1];
          nxt[k].pl[0] = 32'(st[k-1].base) * 32'(st[k-1].gr[0][15:0]);
          nxt[k].pl[1] = 32'(st[k-1].base) * 32'(st[k-1].gr[1][15:0]);
        end
      end else begin : g_out
        always_comb begin
          logic        en;
          logic [31:0] rl, rr;
          en = (ochan >= 4'd2) && st[k-1].nz;
          rl = st[k-1].pl[0] + 32'(RND_Q15);
          rr = st[k-1].pl[1] + 32'(RND_Q15);
          nxt[k]        = st[k-1];
          nxt[k].panned = en;
          nxt[k].left   = en ? rl[30:15] : st[k-1].base;
          nxt[k].right  = en ? rr[30:15] : st[k-1].base;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (rdy[k]) begin
        vld[k] <= upv[k];
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[k]) st[k] <= nxt[k];
    end
  end

  assign m_axis_tvalid = vld[NS-1];
  assign m_axis_tdata  = {7'd0, st[NS-1].panned, st[NS-1].right, st[NS-1].left,
                          st[NS-1].base, st[NS-1].tag};

  a_busy_blocks: assert property (@(posedge clk) disable iff (rst)
    busy |-> !s_axis_tready)
    else $error("request taken while basis sequencer runs");

  a_flat_gain: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !st[NS-1].panned |->
      st[NS-1].left == st[NS-1].base && st[NS-1].right == st[NS-1].base)
    else $error("unpanned result with split gains");

  a_gain_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> st[NS-1].base <= 16'(ONE_Q15) &&
      st[NS-1].left <= 16'(ONE_Q15) && st[NS-1].right <= 16'(ONE_Q15))
    else $error("gain above unity");

endmodule

// File: tb/tb_svgp_checker.sv
`timescale 1ns / 1ps
// gain and pan checker for spatial_voice_gain_pan: snoops apb writes and both streams,
// predicts each result and compares it field by field; depends on svgp_pkg
module tb_svgp_checker
  import svgp_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic [143:0] s_tdata,
  input  logic         s_tvalid,
  input  logic         s_tready,
  input  logic [63:0]  m_tdata,
  input  logic         m_tvalid,
  input  logic         m_tready,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [5:0]   paddr,
  input  logic [63:0]  pwdata,
  input  logic         pready,
  output int           errors,
  output int           pending
);

  typedef longint vec3_t [3];

  typedef struct {
    logic [7:0]  tag;
    logic [15:0] base;
    logic [15:0] left;
    logic [15:0] right;
    logic        panned;
  } gains_t;

  longint      lst_x, lst_y, lst_z;
  logic [47:0] fwd_vec, up_vec;
  logic [3:0]  out_chans;
  gains_t      gains_q[$];

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic vec3_t unpack3(logic [47:0] p);
    vec3_t v;
    v[0] = longint'($signed(p[47:32]));
    v[1] = longint'($signed(p[31:16]));
    v[2] = longint'($signed(p[15:0]));
    return v;
  endfunction

  function automatic vec3_t unit_vec(vec3_t c, longint unsigned tiny, vec3_t fb);
    vec3_t o;
    longint unsigned s, len, mag;
    s = 0;
    for (int i = 0; i < 3; i++) s += longint'(c[i] * c[i]);
    if (s <= tiny) return fb;
    len = int_sqrt(s);
    for (int i = 0; i < 3; i++) begin
      mag = (c[i] < 0) ? -c[i] : c[i];
      o[i] = longint'((mag * 64'd16384) / len);
      if (c[i] < 0) o[i] = -o[i];
    end
    return o;
  endfunction

  function automatic gains_t voice_gains(logic [143:0] t);
    gains_t g;
    vec3_t d, fwn, upn, cr, rn, dn;
    vec3_t fb_f, fb_u, fb_r;
    longint unsigned sumsq, dlen, n, f, att, vol, base, gl, gr;
    longint pan;
    fb_f = '{0, 0, ONE_Q14};
    fb_u = '{0, ONE_Q14, 0};
    fb_r = '{ONE_Q14, 0, 0};
    d[0] = longint'($signed(t[31:8])) - lst_x;
    d[1] = longint'($signed(t[55:32])) - lst_y;
    d[2] = longint'($signed(t[79:56])) - lst_z;
    sumsq = 0;
    for (int i = 0; i < 3; i++) sumsq += longint'(d[i] * d[i]);
    dlen = int_sqrt(sumsq);
    n = t[118:96];
    if (n < 1) n = 1;
    f = t[141:119];
    if (f < n + 1) f = n + 1;
    if (dlen <= n) att = ONE_Q15;
    else if (dlen >= f) att = 0;
    else att = ((f - dlen) * ONE_Q15) / (f - n);
    vol = t[95:80];
    if (vol > ONE_Q15) vol = ONE_Q15;
    base = (vol * att + RND_Q15) >> 15;
    g.tag = t[7:0];
    g.base = base[15:0];
    g.left = base[15:0];
    g.right = base[15:0];
    g.panned = 1'b0;
    if (out_chans >= 2 && sumsq != 0) begin
      fwn = unit_vec(unpack3(fwd_vec), TINY_Q28, fb_f);
      upn = unit_vec(unpack3(up_vec), TINY_Q28, fb_u);
      cr[0] = upn[1] * fwn[2] - upn[2] * fwn[1];
      cr[1] = upn[2] * fwn[0] - upn[0] * fwn[2];
      cr[2] = upn[0] * fwn[1] - upn[1] * fwn[0];
      rn = unit_vec(cr, TINY_Q56, fb_r);
      dn = unit_vec(d, 0, fwn);
      pan = dn[0] * rn[0] + dn[1] * rn[1] + dn[2] * rn[2];
      if (pan > ONE_Q28) pan = ONE_Q28;
      if (pan < -ONE_Q28) pan = -ONE_Q28;
      gl = int_sqrt((ONE_Q28 - pan) * 2);
      gr = int_sqrt((ONE_Q28 + pan) * 2);
      g.left = 16'((base * gl + RND_Q15) >> 15);
      g.right = 16'((base * gr + RND_Q15) >> 15);
      g.panned = 1'b1;
    end
    return g;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      lst_x <= 0;
      lst_y <= 0;
      lst_z <= 0;
      fwd_vec <= 48'd16384;
      up_vec <= 48'd16384 << 16;
      out_chans <= 4'd2;
    end else if (psel && penable && pwrite && pready) begin
      unique case (paddr[5:3])
        REG_LX:    lst_x <= longint'($signed(pwdata[23:0]));
        REG_LY:    lst_y <= longint'($signed(pwdata[23:0]));
        REG_LZ:    lst_z <= longint'($signed(pwdata[23:0]));
        REG_FWD:   fwd_vec <= pwdata[47:0];
        REG_UP:    up_vec <= pwdata[47:0];
        REG_OCHAN: out_chans <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always @(posedge clk) begin
    gains_t e;
    if (!rst && s_tvalid && s_tready) gains_q.push_back(voice_gains(s_tdata));
    if (!rst && m_tvalid && m_tready) begin
      if (gains_q.size() == 0) begin
        $error("unexpected result %h", m_tdata);
        errors++;
      end else begin
        e = gains_q.pop_front();
        if (m_tdata[7:0] !== e.tag) begin
          $error("result_tag exp %0d got %0d", e.tag, m_tdata[7:0]);
          errors++;
        end
        if (m_tdata[23:8] !== e.base) begin
          $error("base_gain exp %0d got %0d", e.base, m_tdata[23:8]);
          errors++;
        end
        if (m_tdata[39:24] !== e.left) begin
          $error("left_gain exp %0d got %0d", e.left, m_tdata[39:24]);
          errors++;
        end
        if (m_tdata[55:40] !== e.right) begin
          $error("right_gain exp %0d got %0d", e.right, m_tdata[55:40]);
          errors++;
        end
        if (m_tdata[56] !== e.panned) begin
          $error("panned exp %0d got %0d", e.panned, m_tdata[56]);
          errors++;
        end
      end
    end
    pending = gains_q.size();
  end

endmodule

// File: tb/tb_spatial_voice_gain_pan.sv
`timescale 1ns / 1ps
// top of the spatial_voice_gain_pan testbench: clock, reset, apb setup phases,
// voice request stimulus and result backpressure; depends on tb_svgp_checker
module tb_spatial_voice_gain_pan;
  import svgp_pkg::*;

  logic         clk;
  logic         rst;
  logic [143:0] s_axis_tdata;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [63:0]  m_axis_tdata;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic         psel, penable, pwrite;
  logic [5:0]   paddr;
  logic [63:0]  pwdata;
  logic [63:0]  prdata;
  logic         pready;
  int           errors, pending;
  bit           idle_on;
  bit           hold_req;
  logic [23:0]  lst[3];

  spatial_voice_gain_pan u_top (.*);

  tb_svgp_checker u_chk (
    .clk(clk), .rst(rst),
    .s_tdata(s_axis_tdata), .s_tvalid(s_axis_tvalid), .s_tready(s_axis_tready),
    .m_tdata(m_axis_tdata), .m_tvalid(m_axis_tvalid), .m_tready(m_axis_tready),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .pready(pready), .errors(errors), .pending(pending)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("** spatial_voice_gain_pan: FAILED **");
    $finish;
  end

  // result side backpressure with one long hold-off
  initial begin
    bit held;
    held = 0;
    m_axis_tready = 0;
    forever begin
      @(posedge clk);
      if (hold_req && !held) begin
        m_axis_tready <= 1'b0;
        repeat (400) @(posedge clk);
        held = 1;
      end
      m_axis_tready <= !(idle_on && $urandom_range(0, 99) < 11);
    end
  end

  task automatic reg_write(logic [2:0] idx, logic [63:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 3'b000};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(negedge clk); while (!pready);
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic send_voice(logic [7:0] tag, logic [23:0] sx, logic [23:0] sy,
                            logic [23:0] sz, logic [15:0] vol, logic [22:0] nd,
                            logic [22:0] fd);
    if (idle_on && $urandom_range(0, 99) < 11) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {2'b00, fd, nd, vol, sz, sy, sx, tag};
    do @(negedge clk); while (!s_axis_tready);
    @(posedge clk);
  endtask

  task automatic set_listener(logic [23:0] x, logic [23:0] y, logic [23:0] z);
    lst[0] = x;
    lst[1] = y;
    lst[2] = z;
    reg_write(REG_LX, {40'd0, x});
    reg_write(REG_LY, {40'd0, y});
    reg_write(REG_LZ, {40'd0, z});
  endtask

  function automatic logic [23:0] near_pos(logic [23:0] c, int span);
    return c + 24'($signed($urandom_range(0, 2 * span)) - span);
  endfunction

  task automatic random_voice();
    int span;
    logic [22:0] nd;
    logic [15:0] vol;
    vol = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(32769, 65535))
                                      : 16'($urandom_range(0, 32768));
    if ($urandom_range(0, 9) < 8) begin
      span = 1 << $urandom_range(2, 16);
      nd = 23'($urandom_range(0, span));
      send_voice(8'($urandom), near_pos(lst[0], span), near_pos(lst[1], span),
                 near_pos(lst[2], span), vol, nd, nd + 23'($urandom_range(0, 2 * span)));
    end else begin
      send_voice(8'($urandom), 24'($urandom), 24'($urandom), 24'($urandom),
                 16'($urandom), 23'($urandom), 23'($urandom));
    end
  endtask

  function automatic logic [63:0] vec_of(int x, int y, int z);
    return {16'd0, 16'(x), 16'(y), 16'(z)};
  endfunction

  initial begin
    int count;
    rst = 1;
    idle_on = 1;
    hold_req = 0;
    s_axis_tvalid = 0;
    s_axis_tdata = '0;
    psel = 0;
    penable = 0;
    pwrite = 0;
    paddr = '0;
    pwdata = '0;
    lst[0] = 0;
    lst[1] = 0;
    lst[2] = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: defaults put right on +x
    send_voice(8'd0, 24'd0, 24'd0, 24'd0, 16'd32768, 23'd0, 23'd0);
    send_voice(8'd255, 24'h7fffff, 24'h7fffff, 24'h7fffff, 16'hffff, 23'h7fffff, 23'h7fffff);
    send_voice(8'd1, 24'h800000, 24'h800000, 24'h800000, 16'd0, 23'd0, 23'd0);
    send_voice(8'd2, 24'd1000, 24'd0, 24'd0, 16'd32768, 23'd100, 23'd5000);
    send_voice(8'd3, -24'sd1000, 24'd0, 24'd0, 16'd32768, 23'd100, 23'd5000);
    send_voice(8'd4, 24'd0, 24'd0, -24'sd700, 16'd20000, 23'd100, 23'd5000);
    send_voice(8'd5, 24'd0, 24'd500, 24'd0, 16'd32767, 23'd0, 23'd0);
    send_voice(8'd6, 24'd300, 24'd0, 24'd300, 16'd40000, 23'd5000, 23'd10);
    send_voice(8'd7, 24'd1, 24'd0, 24'd0, 16'd32768, 23'd0, 23'd2);
    send_voice(8'd8, 24'd100, 24'd100, 24'd100, 16'd32768, 23'h7fffff, 23'h7fffff);
    send_voice(8'd9, 24'd200, 24'd0, 24'd0, 16'd12345, 23'd200, 23'd201);
    send_voice(8'd10, 24'd201, 24'd0, 24'd0, 16'd12345, 23'd200, 23'd201);
    send_voice(8'd11, 24'h555555, 24'haaaaaa, 24'h0f0f0f, 16'h5555, 23'h2aaaaa, 23'h555555);
    send_voice(8'd12, 24'haaaaaa, 24'h555555, 24'hf0f0f0, 16'haaaa, 23'h555555, 23'h2aaaaa);

    for (int ph = 0; ph < 9; ph++) begin
      drain();
      case (ph)
        0: begin
          set_listener(24'($urandom), 24'($urandom), 24'($urandom));
          reg_write(REG_FWD, vec_of(3000, -9000, 12000));
          reg_write(REG_UP, vec_of(-500, 16000, 800));
          reg_write(REG_OCHAN, 64'd2);
        end
        1: begin
          set_listener(24'h7fffff, 24'h7fffff, 24'h7fffff);
          reg_write(REG_FWD, vec_of(0, 0, 10));
          reg_write(REG_UP, vec_of(0, 16384, 0));
          reg_write(REG_OCHAN, 64'd8);
        end
        2: begin
          set_listener(24'h800000, 24'h800000, 24'h800000);
          reg_write(REG_FWD, vec_of(-16384, 0, 0));
          reg_write(REG_UP, 64'd0);
          reg_write(REG_OCHAN, 64'd1);
        end
        3: begin
          set_listener(24'd0, 24'd0, 24'd0);
          reg_write(REG_FWD, vec_of(32767, 32767, 32767));
          reg_write(REG_UP, vec_of(32767, 32767, 32767));
          reg_write(REG_OCHAN, 64'd15);
        end
        4: begin
          reg_write(REG_FWD, vec_of(-32768, -32768, -32768));
          reg_write(REG_UP, vec_of(0, 0, -32768));
          reg_write(REG_OCHAN, 64'd0);
        end
        default: begin
          set_listener(24'($urandom), 24'($urandom), 24'($urandom));
          reg_write(REG_FWD, {$urandom, $urandom});
          reg_write(REG_UP, {$urandom, $urandom});
          reg_write(REG_OCHAN, 64'($urandom_range(0, 15)));
        end
      endcase
      @(posedge clk);
      count = 200;
      for (int i = 0; i < count; i++) begin
        if (ph == 3 && i == 20) hold_req = 1;
        idle_on = !(ph == 5);
        random_voice();
      end
    end

    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (errors == 0)
      $display("** spatial_voice_gain_pan: PASSED **");
    else
      $display("** spatial_voice_gain_pan: FAILED **");
    $finish;
  end

endmodule
